// File: rtl/smhpq_pkg.sv
`timescale 1ns / 1ps

package smhpq_pkg;

	// Heap geometry
	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int LNK_W    = IDX_W + 2;

	// Field widths
	localparam int VAL_W  = 32;
	localparam int PRI_W  = 16;
	localparam int STP_W  = 32;
	localparam int STAT_W = 2;
	localparam int OCC_W  = 5;

	// Operation codes
	localparam logic OP_ENQ = 1'b0;
	localparam logic OP_DEQ = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

	// One heap slot: payload, priority and arrival stamp
	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic [PRI_W-1:0]        prio;
		logic [STP_W-1:0]        stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Outcome of one compare step: right child wins, left wins, or neither
	typedef struct packed {
		logic take_l;
		logic take_r;
	} pick_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_DQ_LOAD,
		S_UP_CMP,
		S_DN_CMP,
		S_PUT,
		S_OUT
	} state_t;

	// True when entry a is served before entry b
	function automatic logic goes_first(entry_t a, entry_t b);
		return (a.prio != b.prio) ? (a.prio < b.prio) : (a.stamp < b.stamp);
	endfunction

endpackage

// File: rtl/smhpq_if.sv
`timescale 1ns / 1ps

interface smhpq_in_if import smhpq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    func;
	logic signed [VAL_W-1:0] item_value;
	logic [PRI_W-1:0]        item_priority;

	modport source(output valid, func, item_value, item_priority, input ready);
	modport sink(input valid, func, item_value, item_priority, output ready);
endinterface

interface smhpq_out_if import smhpq_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [STAT_W-1:0]       status;
	logic signed [VAL_W-1:0] out_value;
	logic [PRI_W-1:0]        out_priority;
	logic [OCC_W-1:0]        occupancy;

	modport source(output valid, status, out_value, out_priority, occupancy, input ready);
	modport sink(input valid, status, out_value, out_priority, occupancy, output ready);
endinterface

// File: rtl/smhpq_ram.sv
`timescale 1ns / 1ps

module smhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read two words with registered output
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

// File: rtl/smhpq_cmp.sv
`timescale 1ns / 1ps

module smhpq_cmp import smhpq_pkg::*; (
	input  entry_t anchor,
	input  entry_t lft,
	input  entry_t rgt,
	input  logic   lft_ok,
	input  logic   rgt_ok,
	output pick_t  pick
);

	logic   l_win;
	logic   r_win;
	entry_t best;

	// Pick the entry served first among anchor and the valid candidates
	always_comb begin
		l_win       = lft_ok && goes_first(lft, anchor);
		best        = l_win ? lft : anchor;
		r_win       = rgt_ok && goes_first(rgt, best);
		pick.take_l = l_win && !r_win;
		pick.take_r = r_win;
	end

endmodule

// File: rtl/stable_min_heap_priority_queue.sv
`timescale 1ns / 1ps

// Bounded min-heap priority queue with stable ordering among equal priorities.
// Channel req carries one operation per item: func 0 enqueues item_value with
// item_priority, func 1 dequeues the entry with the lowest priority number,
// the earliest inserted one on a tie. Channel rsp returns exactly one item per
// request: status (ok, full, empty), the dequeued value and priority (zero
// otherwise) and the occupancy after the operation.
// From acceptance to the result being offered, each request passes through a
// setup state (followed on a dequeue by a state that loads the root and the
// last entry), where needed a compare state that the sift loop repeats once per
// heap level it tests (at most log2(CAPACITY) levels), a place state for an
// entry that rises to the root or goes into an empty heap, then the state that
// loads the result register. Each level is tested by the single compare unit
// on the heap RAM's registered read. req.ready is high only between requests,
// so a new request is not accepted before the block is through with the last.
// The result sits in an output register; while rsp is stalled the block can
// still accept and process the next request, and holds its result until the
// output register is free.
// Reset empties the queue and clears the arrival counter; heap RAM contents
// are not cleared, as only slots below the fill count are ever used.
module stable_min_heap_priority_queue import smhpq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	smhpq_in_if.sink    req,
	smhpq_out_if.source rsp
);

	state_t state_q, state_d;

	logic [CNT_W-1:0]  fill_q;
	logic [STP_W-1:0]  arrival_q;
	logic              op_q;
	entry_t            cur_q;
	logic [IDX_W-1:0]  pos_q, pos_d;
	logic [STAT_W-1:0] status_q;
	logic [VAL_W-1:0]  res_val_q;
	logic [PRI_W-1:0]  res_pri_q;

	logic              out_v_q;
	logic [STAT_W-1:0] out_status_q;
	logic [VAL_W-1:0]  out_val_q;
	logic [PRI_W-1:0]  out_pri_q;
	logic [OCC_W-1:0]  out_occ_q;

	logic              req_fire;
	logic              out_load;
	logic              full;
	logic              empty;
	logic [IDX_W-1:0]  up_idx;
	logic [LNK_W-1:0]  l_idx, r_idx;
	logic [LNK_W-1:0]  l_nxt, r_nxt;
	logic              l_ok, r_ok;

	logic              ram_we;
	logic [IDX_W-1:0]  ram_raddr_a, ram_raddr_b;
	entry_t            ram_wdata;
	logic [ENTRY_W-1:0] rd_a_raw, rd_b_raw;
	entry_t            rd_a, rd_b;

	entry_t            cmp_anchor, cmp_lft;
	logic              cmp_lft_ok, cmp_rgt_ok;
	pick_t             pick;

	assign req_fire = req.valid && req.ready;
	assign full     = (fill_q == CNT_W'(CAPACITY));
	assign empty    = (fill_q == '0);
	assign rd_a     = entry_t'(rd_a_raw);
	assign rd_b     = entry_t'(rd_b_raw);

	// Neighbor indexes of the current slot
	assign up_idx = (pos_q - IDX_W'(1)) >> 1;
	assign l_idx  = {1'b0, pos_q, 1'b1};
	assign r_idx  = l_idx + LNK_W'(1);
	assign l_ok   = l_idx < LNK_W'(fill_q);
	assign r_ok   = r_idx < LNK_W'(fill_q);

	// Steer the shared compare unit: sift up tests the moving entry against
	// its parent, sift down picks the best of the entry and both children
	always_comb begin
		if (op_q == OP_ENQ) begin
			cmp_anchor = rd_a;
			cmp_lft    = cur_q;
			cmp_lft_ok = 1'b1;
			cmp_rgt_ok = 1'b0;
		end else begin
			cmp_anchor = cur_q;
			cmp_lft    = rd_a;
			cmp_lft_ok = l_ok;
			cmp_rgt_ok = r_ok;
		end
	end

	smhpq_cmp u_cmp (
		.anchor (cmp_anchor),
		.lft    (cmp_lft),
		.rgt    (rd_b),
		.lft_ok (cmp_lft_ok),
		.rgt_ok (cmp_rgt_ok),
		.pick   (pick)
	);

	smhpq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (pos_q),
		.wdata   (ram_wdata),
		.raddr_a (ram_raddr_a),
		.raddr_b (ram_raddr_b),
		.rdata_a (rd_a_raw),
		.rdata_b (rd_b_raw)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_fire) state_d = S_START;
			end
			S_START: begin
				if (op_q == OP_ENQ) begin
					if (full) state_d = S_OUT;
					else if (empty) state_d = S_PUT;
					else state_d = S_UP_CMP;
				end else begin
					state_d = empty ? S_OUT : S_DQ_LOAD;
				end
			end
			S_DQ_LOAD: begin
				state_d = (fill_q == CNT_W'(1)) ? S_OUT : S_DN_CMP;
			end
			S_UP_CMP: begin
				if (!pick.take_l) state_d = S_OUT;
				else if (up_idx == '0) state_d = S_PUT;
			end
			S_DN_CMP: begin
				if (!pick.take_l && !pick.take_r) state_d = S_OUT;
			end
			S_PUT: begin
				state_d = S_OUT;
			end
			S_OUT: begin
				if (!out_v_q || rsp.ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Next slot position of the moving entry
	always_comb begin
		pos_d = pos_q;
		unique case (state_q)
			S_START:   pos_d = fill_q[IDX_W-1:0];
			S_DQ_LOAD: pos_d = '0;
			S_UP_CMP:  if (pick.take_l) pos_d = up_idx;
			S_DN_CMP: begin
				if (pick.take_r) pos_d = r_idx[IDX_W-1:0];
				else if (pick.take_l) pos_d = l_idx[IDX_W-1:0];
			end
			default:   pos_d = pos_q;
		endcase
	end

	// Outputs: handshake, RAM port control, result load
	always_comb begin
		l_nxt       = {1'b0, pos_d, 1'b1};
		r_nxt       = l_nxt + LNK_W'(1);
		req.ready   = (state_q == S_IDLE);
		out_load    = (state_q == S_OUT) && (!out_v_q || rsp.ready);
		ram_we      = 1'b0;
		ram_wdata   = cur_q;
		ram_raddr_a = l_nxt[IDX_W-1:0];
		ram_raddr_b = r_nxt[IDX_W-1:0];
		if (op_q == OP_ENQ) begin
			ram_raddr_a = (pos_d - IDX_W'(1)) >> 1;
		end
		if (state_q == S_START && op_q == OP_DEQ) begin
			ram_raddr_a = '0;
			ram_raddr_b = IDX_W'(fill_q - CNT_W'(1));
		end
		unique case (state_q)
			S_UP_CMP: begin
				ram_we    = 1'b1;
				ram_wdata = pick.take_l ? rd_a : cur_q;
			end
			S_DN_CMP: begin
				ram_we = 1'b1;
				if (pick.take_r) ram_wdata = rd_b;
				else if (pick.take_l) ram_wdata = rd_a;
			end
			S_PUT: ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			arrival_q <= '0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_START && op_q == OP_ENQ && !full) begin
				fill_q    <= fill_q + CNT_W'(1);
				arrival_q <= arrival_q + STP_W'(1);
			end
			if (state_q == S_DQ_LOAD) begin
				fill_q <= fill_q - CNT_W'(1);
			end
			if (out_load) out_v_q <= 1'b1;
			else if (rsp.ready) out_v_q <= 1'b0;
		end
	end

	// Working registers: capture request, moving entry, result fields
	always_ff @(posedge clk) begin
		pos_q <= pos_d;
		if (req_fire) begin
			op_q        <= req.func;
			cur_q.value <= req.item_value;
			cur_q.prio  <= req.item_priority;
			cur_q.stamp <= arrival_q;
		end
		if (state_q == S_START) begin
			res_val_q <= '0;
			res_pri_q <= '0;
			if (op_q == OP_ENQ) status_q <= full ? ST_FULL : ST_OK;
			else status_q <= empty ? ST_EMPTY : ST_OK;
		end
		if (state_q == S_DQ_LOAD) begin
			res_val_q <= rd_a.value;
			res_pri_q <= rd_a.prio;
			cur_q     <= rd_b;
		end
		if (out_load) begin
			out_status_q <= status_q;
			out_val_q    <= res_val_q;
			out_pri_q    <= res_pri_q;
			out_occ_q    <= OCC_W'(fill_q);
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = out_status_q;
	assign rsp.out_value    = out_val_q;
	assign rsp.out_priority = out_pri_q;
	assign rsp.occupancy    = out_occ_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(CAPACITY))
		else $error("fill count above capacity");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_EMPTY) |-> (rsp.occupancy == '0))
		else $error("empty status with nonzero occupancy");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == ST_FULL) |-> (rsp.occupancy == OCC_W'(CAPACITY)))
		else $error("full status without full occupancy");

	a_sink_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DN_CMP) |-> (LNK_W'(pos_q) < LNK_W'(fill_q)))
		else $error("sift down position beyond heap");

	a_dq_shrink: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DQ_LOAD) |=> (fill_q == $past(fill_q) - CNT_W'(1)))
		else $error("dequeue did not shrink the heap by one");

endmodule

// File: tb/sv/stable_min_heap_priority_queue_tb.sv
`timescale 1ns / 1ps

module stable_min_heap_priority_queue_tb;
	import smhpq_pkg::*;

	// One stored entry of the heap mirror
	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic [PRI_W-1:0]        prio;
		logic [STP_W-1:0]        stamp;
	} slot_t;

	// One response item as it should leave the block
	typedef struct packed {
		logic [STAT_W-1:0]       status;
		logic signed [VAL_W-1:0] value;
		logic [PRI_W-1:0]        prio;
		logic [OCC_W-1:0]        occ;
	} outcome_t;

	// One row of the opening sequence; pinned rows carry their own outcome
	typedef struct {
		logic     func;
		logic signed [VAL_W-1:0] value;
		logic [PRI_W-1:0]        prio;
		bit       pinned;
		outcome_t want;
	} script_row_t;

	localparam outcome_t NO_PIN = '0;
	localparam int       OPENING_ROWS = 25;
	localparam int       RANDOM_BLOCKS = 12;
	localparam int       BLOCK_ITEMS = 48;
	localparam int       LONG_HOLD = 300;

	logic clk;
	logic arst_n;

	smhpq_in_if  req_if();
	smhpq_out_if rsp_if();

	stable_min_heap_priority_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// Heap mirror
	slot_t       heap_mirror [CAPACITY];
	int          mirror_fill;
	logic [31:0] next_stamp;

	outcome_t pending_outcomes [$];

	int mismatches;
	int checked_items;
	int enq_count;
	int deq_count;
	int full_count;
	int empty_count;
	int peak_fill;

	bit tx_idle;
	bit rx_idle;
	bit hold_req;
	bit hold_done;

	int enq_pct [RANDOM_BLOCKS] = '{85, 50, 15, 90, 30, 70, 10, 60, 95, 20, 50, 50};

	script_row_t opening_rows [OPENING_ROWS] = '{
		'{OP_DEQ, 32'sd0, 16'd0, 1'b1, '{ST_EMPTY, 32'sd0, 16'd0, 5'd0}},
		'{OP_ENQ, 32'sh7FFF_FFFF, 16'hFFFF, 1'b1, '{ST_OK, 32'sd0, 16'd0, 5'd1}},
		'{OP_ENQ, 32'sh8000_0000, 16'h0000, 1'b1, '{ST_OK, 32'sd0, 16'd0, 5'd2}},
		'{OP_DEQ, 32'sd0, 16'd0, 1'b1, '{ST_OK, 32'sh8000_0000, 16'h0000, 5'd1}},
		'{OP_DEQ, 32'sd0, 16'd0, 1'b1, '{ST_OK, 32'sh7FFF_FFFF, 16'hFFFF, 5'd0}},
		'{OP_ENQ, 32'sd101, 16'd4, 1'b0, NO_PIN},
		'{OP_ENQ, -32'sd102, 16'd4, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd103, 16'd2, 1'b0, NO_PIN},
		'{OP_ENQ, -32'sd104, 16'd4, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd105, 16'd0, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd106, 16'd2, 1'b0, NO_PIN},
		'{OP_ENQ, -32'sd107, 16'hFFFF, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd108, 16'd4, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd109, 16'd2, 1'b0, NO_PIN},
		'{OP_ENQ, -32'sd110, 16'd0, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd111, 16'd7, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd112, 16'd4, 1'b0, NO_PIN},
		'{OP_ENQ, -32'sd113, 16'd1, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd114, 16'd0, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd115, 16'd4, 1'b0, NO_PIN},
		'{OP_ENQ, -32'sd116, 16'd2, 1'b0, NO_PIN},
		'{OP_ENQ, 32'sd117, 16'd0, 1'b1, '{ST_FULL, 32'sd0, 16'd0, 5'd16}},
		'{OP_DEQ, 32'sd0, 16'd0, 1'b0, NO_PIN},
		'{OP_DEQ, 32'sd0, 16'd0, 1'b0, NO_PIN},
		'{OP_DEQ, 32'sd0, 16'd0, 1'b0, NO_PIN}
	};

	// Clock: 20 ns period
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Lower priority number first, earlier stamp on a tie
	function automatic bit served_before(slot_t a, slot_t b);
		if (a.prio != b.prio)
			return a.prio < b.prio;
		return a.stamp < b.stamp;
	endfunction

	// Apply one operation to the heap mirror and return its outcome
	function automatic outcome_t heap_update(logic func, logic signed [VAL_W-1:0] value,
			logic [PRI_W-1:0] prio);
		outcome_t res;
		slot_t    tmp;
		int       pos;
		int       up;
		int       best;
		int       lc;
		int       rc;
		res = '0;
		res.status = ST_OK;
		if (func == OP_ENQ) begin
			if (mirror_fill >= CAPACITY) begin
				res.status = ST_FULL;
			end else begin
				// Place at the tail and sift up
				pos = mirror_fill;
				heap_mirror[pos] = '{value, prio, next_stamp};
				next_stamp = next_stamp + 32'd1;
				while (pos > 0) begin
					up = (pos - 1) / 2;
					if (!served_before(heap_mirror[pos], heap_mirror[up]))
						break;
					tmp = heap_mirror[pos];
					heap_mirror[pos] = heap_mirror[up];
					heap_mirror[up] = tmp;
					pos = up;
				end
				mirror_fill++;
			end
		end else begin
			if (mirror_fill == 0) begin
				res.status = ST_EMPTY;
			end else begin
				// Take the root, move the tail up and sift down
				res.value = heap_mirror[0].value;
				res.prio = heap_mirror[0].prio;
				mirror_fill--;
				heap_mirror[0] = heap_mirror[mirror_fill];
				pos = 0;
				forever begin
					best = pos;
					lc = 2 * pos + 1;
					rc = 2 * pos + 2;
					if (lc < mirror_fill && served_before(heap_mirror[lc], heap_mirror[best]))
						best = lc;
					if (rc < mirror_fill && served_before(heap_mirror[rc], heap_mirror[best]))
						best = rc;
					if (best == pos)
						break;
					tmp = heap_mirror[pos];
					heap_mirror[pos] = heap_mirror[best];
					heap_mirror[best] = tmp;
					pos = best;
				end
			end
		end
		res.occ = OCC_W'(mirror_fill);
		return res;
	endfunction

	// Offer one item, wait for acceptance and queue its outcome
	task automatic offer_op(input logic func, input logic signed [VAL_W-1:0] value,
			input logic [PRI_W-1:0] prio, input bit pinned, input outcome_t want);
		outcome_t predicted;
		req_if.valid <= 1'b1;
		req_if.func <= func;
		req_if.item_value <= value;
		req_if.item_priority <= prio;
		do
			@(posedge clk);
		while (!req_if.ready);
		predicted = heap_update(func, value, prio);
		pending_outcomes.push_back(pinned ? want : predicted);
		if (func == OP_ENQ)
			enq_count++;
		else
			deq_count++;
		if (predicted.status == ST_FULL)
			full_count++;
		if (predicted.status == ST_EMPTY)
			empty_count++;
		if (predicted.occ > peak_fill)
			peak_fill = predicted.occ;
	endtask

	// Drop valid for a short burst now and then
	task automatic sender_gap();
		if (tx_idle && $urandom_range(0, 3) == 0) begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Compare one response item with the oldest outcome
	task automatic check_outcome();
		outcome_t want;
		checked_items++;
		if (pending_outcomes.size() == 0) begin
			$display("%0t: unexpected item: status %0d value %0d priority %0d occupancy %0d",
				$time, rsp_if.status, rsp_if.out_value, rsp_if.out_priority,
				rsp_if.occupancy);
			mismatches++;
		end else begin
			want = pending_outcomes.pop_front();
			if (rsp_if.status !== want.status) begin
				$display("%0t: status expected %0d actual %0d",
					$time, want.status, rsp_if.status);
				mismatches++;
			end
			if (rsp_if.out_value !== want.value) begin
				$display("%0t: out_value expected %0d actual %0d",
					$time, want.value, rsp_if.out_value);
				mismatches++;
			end
			if (rsp_if.out_priority !== want.prio) begin
				$display("%0t: out_priority expected %0d actual %0d",
					$time, want.prio, rsp_if.out_priority);
				mismatches++;
			end
			if (rsp_if.occupancy !== want.occ) begin
				$display("%0t: occupancy expected %0d actual %0d",
					$time, want.occ, rsp_if.occupancy);
				mismatches++;
			end
		end
	endtask

	// Response side: check items, stall in bursts, hold off once for a long stretch
	initial begin : drain
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready)
				check_outcome();
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_if.ready <= 1'b0;
			end else if (rx_idle && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Request side and run control
	initial begin : stimulus
		logic func;
		logic [PRI_W-1:0] prio;
		mirror_fill = 0;
		next_stamp = '0;
		mismatches = 0;
		checked_items = 0;
		enq_count = 0;
		deq_count = 0;
		full_count = 0;
		empty_count = 0;
		peak_fill = 0;
		tx_idle = 1'b1;
		rx_idle = 1'b1;
		hold_req = 1'b0;
		arst_n = 1'b0;
		req_if.valid <= 1'b0;
		req_if.func <= OP_ENQ;
		req_if.item_value <= '0;
		req_if.item_priority <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Opening sequence: extremes, empty and full, ties in priority
		foreach (opening_rows[i]) begin
			offer_op(opening_rows[i].func, opening_rows[i].value, opening_rows[i].prio,
				opening_rows[i].pinned, opening_rows[i].want);
			sender_gap();
		end

		// Random blocks with a shifting enqueue share; the last two run without idling
		for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
			tx_idle = (blk < RANDOM_BLOCKS - 2) && (blk % 3 != 2);
			rx_idle = (blk < RANDOM_BLOCKS - 2) && (blk % 3 != 1);
			if (blk == 3)
				hold_req = 1'b1;
			for (int n = 0; n < BLOCK_ITEMS; n++) begin
				func = ($urandom_range(1, 100) <= enq_pct[blk]) ? OP_ENQ : OP_DEQ;
				case ($urandom_range(0, 9))
					0: begin
						prio = 16'h0000;
					end
					1: begin
						prio = 16'hFFFF;
					end
					2, 3: begin
						prio = PRI_W'($urandom);
					end
					default: begin
						prio = PRI_W'($urandom_range(0, 5));
					end
				endcase
				offer_op(func, $urandom, prio, 1'b0, NO_PIN);
				sender_gap();
			end
		end
		req_if.valid <= 1'b0;

		// Let every outcome arrive, then allow for stray items
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Run covered %0d enqueues (%0d refused as full) and %0d dequeues (%0d on empty),",
			enq_count, full_count, deq_count, empty_count);
		$display("peak fill %0d of %0d, %0d response items checked, %0d bad fields.",
			peak_fill, CAPACITY, checked_items, mismatches);
		if (mismatches == 0 && pending_outcomes.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// Watchdog
	initial begin : watchdog
		#2_000_000;
		$display("%0t: timeout with %0d outcomes outstanding", $time, pending_outcomes.size());
		$display("Mismatches found");
		$finish;
	end

endmodule
